// ===== rtl/irl_pkg.sv =====
// ----------------------------------------------------------------------------
// irl_pkg
// Shared widths, limits and register indexes of the image resizer.
// ----------------------------------------------------------------------------
package irl_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned TGT_W        = 13;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned TARGET_LIMIT = 4096;
  localparam int unsigned REG_IDX_W    = 3;
  localparam int unsigned REG_DATA_W   = 13;

  localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TGT_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TGT_HEIGHT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS   = 3'd5;

  localparam logic MODE_NEAREST = 1'b1;

endpackage

// ===== rtl/image_resize_bilinear_nearest.sv =====
// ----------------------------------------------------------------------------
// image_resize_bilinear_nearest
// Frame store plus bilinear or nearest resampler for 8-bit, 1..4 channel images.
// ----------------------------------------------------------------------------
// A load beat is written in the cycle it is accepted. An emit beat runs
// through multiply, position, weight, four store reads, final accumulate
// and output; the first pixel of a frame first runs the step divider. One
// item is in work at a time: loads are taken one per cycle while no emit
// beat is in work, and a new emit beat is not taken until the last one has
// left the output stage. Reset clears counters, steps, configuration
// registers and the output valid flag; the frame store and the output data
// are not cleared.
module image_resize_bilinear_nearest import irl_pkg::*; #(
  parameter int unsigned MAX_SIDE        = 256,
  parameter int unsigned MAX_CHANNELS    = 4,
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned WEIGHT_BITS     = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [REG_IDX_W-1:0]  cfg_index_i,
  input  logic [REG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [BYTE_W-1:0]     in_c0_i,
  input  logic [BYTE_W-1:0]     in_c1_i,
  input  logic [BYTE_W-1:0]     in_c2_i,
  input  logic [BYTE_W-1:0]     in_c3_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BYTE_W-1:0]     out_c0_o,
  output logic [BYTE_W-1:0]     out_c1_o,
  output logic [BYTE_W-1:0]     out_c2_o,
  output logic [BYTE_W-1:0]     out_c3_o,
  output logic                  frame_last_o
);

  localparam int unsigned F     = COORD_FRAC_BITS;
  localparam int unsigned WB    = WEIGHT_BITS;
  localparam int unsigned SZW   = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW    = $clog2(MAX_SIDE);
  localparam int unsigned AW    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned NUM_W = SZW + F + 1;
  localparam int unsigned PW    = NUM_W + IDX_W + 1;
  localparam int unsigned WW    = WB + 1;
  localparam int unsigned CWW   = 2 * WW;
  localparam logic [PW-1:0] ONE = PW'(1) << F;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL, S_POS, S_WGT, S_RD, S_ACC, S_OUT
  } state_e;

  typedef struct packed {
    logic [CW-1:0] near;
    logic [CW-1:0] far;
    logic [WB-1:0] frac;
  } axis_t;

  // Configuration registers, as written.
  logic                  mode_q;
  logic [8:0]            src_w_q, src_h_q;
  logic [TGT_W-1:0]      tgt_w_q, tgt_h_q;
  logic [2:0]            chan_q;

  // Out-of-range register values are folded into the legal range.
  function automatic logic [TGT_W-1:0] clamp_f(input logic [TGT_W-1:0] v,
                                               input logic [TGT_W-1:0] hi);
    if (v == '0) begin
      return TGT_W'(1);
    end
    return (v > hi) ? hi : v;
  endfunction

  logic [SZW-1:0]   sw, sh;
  logic [TGT_W-1:0] tw, th;
  logic [2:0]       nc;

  always_comb begin
    sw = SZW'(clamp_f(TGT_W'(src_w_q), TGT_W'(MAX_SIDE)));
    sh = SZW'(clamp_f(TGT_W'(src_h_q), TGT_W'(MAX_SIDE)));
    tw = clamp_f(tgt_w_q, TGT_W'(TARGET_LIMIT));
    th = clamp_f(tgt_h_q, TGT_W'(TARGET_LIMIT));
    nc = 3'(clamp_f(TGT_W'(chan_q), TGT_W'(MAX_CHANNELS)));
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      tgt_w_q <= 13'd256;
      tgt_h_q <= 13'd256;
      chan_q  <= 3'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:       mode_q  <= cfg_data_i[0];
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i[8:0];
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i[8:0];
        REG_TGT_WIDTH:  tgt_w_q <= cfg_data_i;
        REG_TGT_HEIGHT: tgt_h_q <= cfg_data_i;
        REG_CHANNELS:   chan_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Input handshake and position counters. Every accepted beat first wraps
  // its counter if a size shrank under it, then advances in raster order.
  // -------------------------------------------------------------------------
  state_e state_q;
  logic   in_fire, load_fire, emit_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && !action_i;
  assign emit_fire  = in_fire && action_i;

  logic [CW-1:0]  ld_col_q, ld_row_q;
  logic [CW-1:0]  ld_col_w, ld_row_w;
  logic [SZW:0]   ld_row_t;
  logic [IDX_W-1:0] em_col_q, em_row_q;
  logic [IDX_W-1:0] em_col_w, em_row_w;
  logic [TGT_W:0]   em_row_t;
  logic             em_col_end, em_row_end, frame_start;

  always_comb begin
    ld_col_w = (SZW'(ld_col_q) >= sw) ? '0 : ld_col_q;
    ld_row_t = (SZW'(ld_col_q) >= sw) ? (SZW + 1)'(ld_row_q) + 1'b1 : (SZW + 1)'(ld_row_q);
    ld_row_w = (ld_row_t >= (SZW + 1)'(sh)) ? '0 : ld_row_t[CW-1:0];

    em_col_w = (TGT_W'(em_col_q) >= tw) ? '0 : em_col_q;
    em_row_t = (TGT_W'(em_col_q) >= tw) ? (TGT_W + 1)'(em_row_q) + 1'b1
                                        : (TGT_W + 1)'(em_row_q);
    em_row_w = (em_row_t >= (TGT_W + 1)'(th)) ? '0 : em_row_t[IDX_W-1:0];

    em_col_end  = (TGT_W'(em_col_w) + 1'b1 >= tw);
    em_row_end  = (TGT_W'(em_row_w) + 1'b1 >= th);
    frame_start = (em_col_w == '0) && (em_row_w == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_col_q <= '0;
      ld_row_q <= '0;
      em_col_q <= '0;
      em_row_q <= '0;
    end else begin
      if (load_fire) begin
        if (SZW'(ld_col_w) + 1'b1 >= sw) begin
          ld_col_q <= '0;
          ld_row_q <= (SZW'(ld_row_w) + 1'b1 >= sh) ? '0 : ld_row_w + 1'b1;
        end else begin
          ld_col_q <= ld_col_w + 1'b1;
          ld_row_q <= ld_row_w;
        end
      end
      if (emit_fire) begin
        if (em_col_end) begin
          em_col_q <= '0;
          em_row_q <= em_row_end ? '0 : em_row_w + 1'b1;
        end else begin
          em_col_q <= em_col_w + 1'b1;
          em_row_q <= em_row_w;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Frame store: one write port for load beats, one registered read port.
  // Channels at or above the channel count are stored as zero.
  // -------------------------------------------------------------------------
  logic [WORD_W-1:0] store_mem [DEPTH];
  logic [WORD_W-1:0] wr_word, rd_word_q;
  logic [AW-1:0]     wr_addr, rd_addr;

  always_comb begin
    wr_word = '0;
    if (nc > 3'd0) wr_word[7:0]   = in_c0_i;
    if (nc > 3'd1) wr_word[15:8]  = in_c1_i;
    if (nc > 3'd2) wr_word[23:16] = in_c2_i;
    if (nc > 3'd3) wr_word[31:24] = in_c3_i;
    wr_addr = AW'(ld_row_w) * AW'(MAX_SIDE) + AW'(ld_col_w);
  end

  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      store_mem[wr_addr] <= wr_word;
    end
    rd_word_q <= store_mem[rd_addr];
  end

  // -------------------------------------------------------------------------
  // Step dividers: ceil(source << F / target), run at the first pixel of each
  // destination frame and held for the rest of it.
  // -------------------------------------------------------------------------
  logic             div_start;
  logic             div_done_x, div_done_y;
  logic [NUM_W-1:0] num_x, num_y, quo_x, quo_y;
  logic [NUM_W-1:0] step_x_q, step_y_q;

  assign div_start = emit_fire && frame_start;
  assign num_x     = (NUM_W'(sw) << F) + NUM_W'(tw) - 1'b1;
  assign num_y     = (NUM_W'(sh) << F) + NUM_W'(th) - 1'b1;

  irl_div #(.NUM_W(NUM_W)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x),
    .den_i   (tw),
    .done_o  (div_done_x),
    .quo_o   (quo_x)
  );

  irl_div #(.NUM_W(NUM_W)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y),
    .den_i   (th),
    .done_o  (div_done_y),
    .quo_o   (quo_y)
  );

  // -------------------------------------------------------------------------
  // Source position per axis. Nearest mode truncates index * step and clips
  // it; bilinear uses the half-pixel center, clamped at zero, with the far
  // neighbor pinned at the last row or column. Nearest mode is run through
  // the same datapath with a zero fraction, so the near pixel gets full weight.
  // -------------------------------------------------------------------------
  function automatic axis_t axis_f(input logic [PW-1:0] prod,
                                   input logic [SZW-1:0] size,
                                   input logic nearest);
    logic [PW-1:0]   pos;
    logic [PW-F-1:0] ip;
    logic [F-1:0]    fr;
    logic [CW-1:0]   last;
    logic [F+WB-1:0] wide;
    axis_t           r;
    last = CW'(size - 1'b1);
    if (nearest) begin
      pos = prod;
    end else begin
      pos = (prod > ONE) ? ((prod - ONE) >> 1) : '0;
    end
    ip = pos[PW-1:F];
    fr = nearest ? '0 : pos[F-1:0];
    if (ip > (PW - F)'(last)) begin
      r.near = last;
      fr     = '0;
    end else begin
      r.near = ip[CW-1:0];
    end
    wide   = {fr, {WB{1'b0}}};
    r.frac = wide[F+WB-1:F];
    r.far  = (nearest || (r.near == last)) ? r.near : r.near + 1'b1;
    return r;
  endfunction

  logic [IDX_W-1:0] cur_col_q, cur_row_q;
  logic             last_q;
  logic [PW-1:0]    prod_x_q, prod_y_q;
  logic [IDX_W:0]   mul_x, mul_y;
  axis_t            ax_x, ax_y;
  axis_t            ax_x_q, ax_y_q;
  logic [WW-1:0]    wx1, wx2, wy1, wy2;
  logic [CWW-1:0]   wgt_q [4];
  logic [1:0]       rd_cnt_q;
  logic [1:0]       acc_sel_q;
  logic             acc_en_q;
  logic [CW-1:0]    rd_row, rd_col;

  always_comb begin
    if (mode_q == MODE_NEAREST) begin
      mul_x = (IDX_W + 1)'(cur_col_q);
      mul_y = (IDX_W + 1)'(cur_row_q);
    end else begin
      mul_x = {cur_col_q, 1'b1};
      mul_y = {cur_row_q, 1'b1};
    end
    ax_x = axis_f(prod_x_q, sw, mode_q == MODE_NEAREST);
    ax_y = axis_f(prod_y_q, sh, mode_q == MODE_NEAREST);

    wx2 = WW'(ax_x_q.frac);
    wy2 = WW'(ax_y_q.frac);
    wx1 = (WW'(1) << WB) - wx2;
    wy1 = (WW'(1) << WB) - wy2;

    // Neighbor order: near/near, far column, far row, far/far.
    rd_col  = rd_cnt_q[0] ? ax_x_q.far : ax_x_q.near;
    rd_row  = rd_cnt_q[1] ? ax_y_q.far : ax_y_q.near;
    rd_addr = AW'(rd_row) * AW'(MAX_SIDE) + AW'(rd_col);
  end

  // -------------------------------------------------------------------------
  // Sequencer for one emit beat.
  // -------------------------------------------------------------------------
  logic out_free;
  logic out_load;

  assign out_free = !out_valid_o || out_ready_i;
  assign out_load = (state_q == S_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_cnt_q  <= '0;
      acc_en_q  <= 1'b0;
      acc_sel_q <= '0;
      step_x_q  <= '0;
      step_y_q  <= '0;
    end else begin
      acc_en_q  <= (state_q == S_RD);
      acc_sel_q <= rd_cnt_q;
      case (state_q)
        S_IDLE: begin
          if (emit_fire) begin
            state_q <= frame_start ? S_DIV : S_MUL;
          end
        end
        S_DIV: begin
          if (div_done_x && div_done_y) begin
            step_x_q <= quo_x;
            step_y_q <= quo_y;
            state_q  <= S_MUL;
          end
        end
        S_MUL: state_q <= S_POS;
        S_POS: state_q <= S_WGT;
        S_WGT: begin
          rd_cnt_q <= '0;
          state_q  <= S_RD;
        end
        S_RD: begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (rd_cnt_q == 2'd3) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the emit sequence; no reset needed.
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      cur_col_q <= em_col_w;
      cur_row_q <= em_row_w;
      last_q    <= em_col_end && em_row_end;
    end
    if (state_q == S_MUL) begin
      prod_x_q <= PW'(mul_x) * PW'(step_x_q);
      prod_y_q <= PW'(mul_y) * PW'(step_y_q);
    end
    if (state_q == S_POS) begin
      ax_x_q <= ax_x;
      ax_y_q <= ax_y;
    end
    if (state_q == S_WGT) begin
      wgt_q[0] <= CWW'(wx1) * CWW'(wy1);
      wgt_q[1] <= CWW'(wx2) * CWW'(wy1);
      wgt_q[2] <= CWW'(wx1) * CWW'(wy2);
      wgt_q[3] <= CWW'(wx2) * CWW'(wy2);
    end
  end

  // -------------------------------------------------------------------------
  // Channel lanes, one per channel, and the merge into the output register.
  // -------------------------------------------------------------------------
  logic [BYTE_W-1:0] lane_val [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    if (k < MAX_CHANNELS) begin : g_on
      irl_lane #(.WEIGHT_BITS(WB)) u_lane (
        .clk_i (clk_i),
        .clr_i (state_q == S_WGT),
        .en_i  (acc_en_q),
        .pix_i (rd_word_q[BYTE_W*k +: BYTE_W]),
        .wgt_i (wgt_q[acc_sel_q]),
        .val_o (lane_val[k])
      );
    end else begin : g_off
      assign lane_val[k] = '0;
    end
  end

  logic [BYTE_W-1:0] out_c_q [4];
  logic              out_valid_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int k = 0; k < 4; k++) begin
        out_c_q[k] <= (3'(k) < nc) ? lane_val[k] : '0;
      end
      out_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_c0_o     = out_c_q[0];
  assign out_c1_o     = out_c_q[1];
  assign out_c2_o     = out_c_q[2];
  assign out_c3_o     = out_c_q[3];
  assign frame_last_o = out_last_q;

endmodule

// ===== rtl/irl_div.sv =====
// ----------------------------------------------------------------------------
// irl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module irl_div import irl_pkg::*; #(
  parameter int unsigned NUM_W = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [TGT_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [TGT_W-1:0] den_q;
  logic [TGT_W:0]   rem_q, rem_d, trial;
  logic [NUM_W-1:0] sh_q, sh_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic             bit_set;

  always_comb begin
    trial   = {rem_q[TGT_W-1:0], sh_q[NUM_W-1]};
    bit_set = (trial >= {1'b0, den_q});
    rem_d   = bit_set ? (trial - {1'b0, den_q}) : trial;
    sh_d    = {sh_q[NUM_W-2:0], bit_set};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      sh_q  <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// ===== rtl/irl_lane.sv =====
// ----------------------------------------------------------------------------
// irl_lane
// One channel lane: accumulates weighted neighbor bytes, then rounds and
// saturates the sum back to a byte.
// ----------------------------------------------------------------------------
module irl_lane import irl_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = 11
) (
  input  logic                       clk_i,
  input  logic                       clr_i,
  input  logic                       en_i,
  input  logic [BYTE_W-1:0]          pix_i,
  input  logic [2*WEIGHT_BITS+1:0]   wgt_i,
  output logic [BYTE_W-1:0]          val_o
);

  localparam int unsigned WGT_W = 2 * WEIGHT_BITS + 2;
  localparam int unsigned ACC_W = BYTE_W + WGT_W + 2;

  logic [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0] rounded;
  logic [ACC_W-1:0] scaled;

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_q + ACC_W'(pix_i) * ACC_W'(wgt_i);
    end
  end

  always_comb begin
    rounded = acc_q + (ACC_W'(1) << (2 * WEIGHT_BITS - 1));
    scaled  = rounded >> (2 * WEIGHT_BITS);
    val_o   = (scaled > ACC_W'(255)) ? 8'hFF : scaled[BYTE_W-1:0];
  end

endmodule
